FILE: src/indexed_priority_task_table_unit_assert.svh
// ----------------------------------------------------------------------------
// Indexed priority task table assertion macros
// Shared concurrent checks, clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef INDEXED_PRIORITY_TASK_TABLE_UNIT_ASSERT_SVH
`define INDEXED_PRIORITY_TASK_TABLE_UNIT_ASSERT_SVH

// condition holds in the same cycle
`define ITT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition holds in the next cycle
`define ITT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/itt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed priority task table package
// Payload types, heap entry layout, codes and the heap ordering function
// ----------------------------------------------------------------------------
package itt_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int ID_SPACE_DEF = 128;

  localparam int FUNC_W     = 3;
  localparam int ID_W       = 7;
  localparam int DUR_W      = 16;
  localparam int PRIO_W     = 8;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 6;
  localparam int TICK_W     = 32;
  localparam int FLAGS_W    = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [FUNC_W-1:0] FUNC_TICK     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD      = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPLETE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CANCEL   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_RETIME   = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_SETPRIO  = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_PAUSE    = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_RESUME   = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DONE       = 3'd4;
  localparam logic [STATUS_W-1:0] ST_PAUSED     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NOT_PAUSED = 3'd6;

  localparam int FLAG_DONE_BIT   = 0;
  localparam int FLAG_PAUSED_BIT = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_TPM  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFP = 1'b1;

  localparam logic [DUR_W-1:0]  TPM_RESET  = 16'd60;
  localparam logic [PRIO_W-1:0] DEFP_RESET = 8'd1;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   task_id;
    logic [DUR_W-1:0]  duration;
    logic [PRIO_W-1:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                auto_done;
    logic [ID_W-1:0]     done_id;
    logic                head_valid;
    logic [ID_W-1:0]     head_id;
    logic [COUNT_W-1:0]  task_count;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]    task_id;
    logic [PRIO_W-1:0]  prio;
    logic [DUR_W-1:0]   dur;
    logic [TICK_W-1:0]  start;
    logic [FLAGS_W-1:0] flags;
  } heap_entry_t;

  localparam int ENTRY_W = $bits(heap_entry_t);

  // a sits above b: higher priority, then shorter duration
  function automatic logic goes_before(heap_entry_t a, heap_entry_t b);
    if (a.prio != b.prio) begin
      return a.prio > b.prio;
    end
    return a.dur < b.dur;
  endfunction

endpackage

FILE: src/itt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data
// ----------------------------------------------------------------------------
module itt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/indexed_priority_task_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed priority task table
// Task heap with slot map held in two RAMs, walked by one sequencer
// ----------------------------------------------------------------------------
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_ready    | in_data (in_item_t)
// out     | output    | out_valid / out_ready  | out_data (out_item_t)
// cfg     | input     | cfg_we                 | cfg_index, cfg_data
//
// one item at a time; in_ready is high only while the sequencer is idle
// sift: UP_RD then UP_CMP per level up, DN_RDL, DN_RDR then DN_CMP per level down, over the heap RAM port
// tick: each held task is read, multiplied and compared; each completion adds an emit step
// results sit in an output register, so a new item is taken while one waits
// rst is synchronous; no clearing pass, task presence lives in flip-flops
// ----------------------------------------------------------------------------
`include "indexed_priority_task_table_unit_assert.svh"

module indexed_priority_task_table_unit
  import itt_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int ID_SPACE = ID_SPACE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int IW = $clog2(ID_SPACE);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_LOOK   = 13'b0000000000010,
    S_FETCH  = 13'b0000000000100,
    S_UP_RD  = 13'b0000000001000,
    S_UP_CMP = 13'b0000000010000,
    S_DN_RDL = 13'b0000000100000,
    S_DN_RDR = 13'b0000001000000,
    S_DN_CMP = 13'b0000010000000,
    S_T_RD   = 13'b0000100000000,
    S_T_MUL  = 13'b0001000000000,
    S_T_CMP  = 13'b0010000000000,
    S_T_EMIT = 13'b0100000000000,
    S_EMIT   = 13'b1000000000000
  } state_t;

  state_t               state, state_next;
  logic [COUNT_W-1:0]   count, count_next;
  logic [TICK_W-1:0]    now_tick, now_tick_next;
  logic [ID_SPACE-1:0]  present, present_next;
  logic [DUR_W-1:0]     tpm;
  logic [PRIO_W-1:0]    defp;
  logic [ID_W-1:0]      head, head_next;
  logic [FUNC_W-1:0]    op, op_next;
  logic [ID_W-1:0]      id_r, id_r_next;
  logic [DUR_W-1:0]     dur_r, dur_r_next;
  logic [PRIO_W-1:0]    preq_r, preq_r_next;
  logic [STATUS_W-1:0]  status_r, status_r_next;
  heap_entry_t          ent, ent_next;
  heap_entry_t          cand, cand_next;
  logic                 r_ok, r_ok_next;
  logic [AW-1:0]        idx, idx_next;
  logic [COUNT_W-1:0]   tidx, tidx_next;
  logic [TICK_W-1:0]    elapsed, elapsed_next;
  logic [TICK_W-1:0]    need, need_next;
  logic                 out_valid_next;
  out_item_t            out_data_next;

  logic                 hw_en;
  logic [AW-1:0]        hw_addr;
  heap_entry_t          hw_data;
  logic [AW-1:0]        hr_addr;
  heap_entry_t          hr_data;
  logic                 sw_en;
  logic [IW-1:0]        sw_addr;
  logic [AW-1:0]        sw_data;
  logic [IW-1:0]        sr_addr;
  logic [AW-1:0]        sr_data;

  logic                 out_free;
  logic                 in_range;
  logic [IW-1:0]        in_id;
  logic [AW-1:0]        parent;
  logic [COUNT_W:0]     lchild, rchild;
  logic                 take_l, take_r;
  heap_entry_t          best_lr;
  logic [COUNT_W-1:0]   tidx_inc;
  logic                 head_valid;
  logic [ID_W-1:0]      head_out;

  itt_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_heap_ram (
    .clk   (clk),
    .we    (hw_en),
    .waddr (hw_addr),
    .wdata (hw_data),
    .raddr (hr_addr),
    .rdata (hr_data)
  );

  itt_ram #(.WIDTH(AW), .DEPTH(ID_SPACE)) u_slot_ram (
    .clk   (clk),
    .we    (sw_en),
    .waddr (sw_addr),
    .wdata (sw_data),
    .raddr (sr_addr),
    .rdata (sr_data)
  );

  assign in_ready   = (state == S_IDLE);
  assign out_free   = !out_valid || out_ready;
  assign in_range   = (32'(in_data.task_id) < ID_SPACE);
  assign in_id      = IW'(in_data.task_id);
  assign parent     = (idx - AW'(1)) >> 1;
  assign lchild     = ((COUNT_W + 1)'(idx) << 1) + (COUNT_W + 1)'(1);
  assign rchild     = ((COUNT_W + 1)'(idx) << 1) + (COUNT_W + 1)'(2);
  assign take_l     = goes_before(cand, ent);
  assign best_lr    = take_l ? cand : ent;
  assign take_r     = r_ok && goes_before(hr_data, best_lr);
  assign tidx_inc   = tidx + COUNT_W'(1);
  assign head_valid = (count != '0);
  assign head_out   = head_valid ? head : '0;

  always_comb begin
    state_next     = state;
    count_next     = count;
    now_tick_next  = now_tick;
    present_next   = present;
    head_next      = head;
    op_next        = op;
    id_r_next      = id_r;
    dur_r_next     = dur_r;
    preq_r_next    = preq_r;
    status_r_next  = status_r;
    ent_next       = ent;
    cand_next      = cand;
    r_ok_next      = r_ok;
    idx_next       = idx;
    tidx_next      = tidx;
    elapsed_next   = elapsed;
    need_next      = need;
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;
    hw_en          = 1'b0;
    hw_addr        = idx;
    hw_data        = ent;
    hr_addr        = '0;
    sw_en          = 1'b0;
    sw_addr        = IW'(ent.task_id);
    sw_data        = idx;
    sr_addr        = in_id;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next       = in_data.func;
          id_r_next     = in_data.task_id;
          dur_r_next    = in_data.duration;
          preq_r_next   = in_data.priority_req;
          status_r_next = ST_OK;
          if (in_data.func == FUNC_TICK) begin
            now_tick_next = now_tick + TICK_W'(1);
            tidx_next     = '0;
            state_next    = (count == '0) ? S_EMIT : S_T_RD;
          end else if (!in_range) begin
            status_r_next = ST_NOT_FOUND;
            state_next    = S_EMIT;
          end else if (in_data.func == FUNC_ADD) begin
            if (count >= COUNT_W'(CAPACITY)) begin
              status_r_next = ST_FULL;
              state_next    = S_EMIT;
            end else if (present[in_id]) begin
              status_r_next = ST_DUPLICATE;
              state_next    = S_EMIT;
            end else begin
              present_next[in_id] = 1'b1;
              ent_next.task_id    = in_data.task_id;
              ent_next.prio       = defp;
              ent_next.dur        = in_data.duration;
              ent_next.start      = now_tick;
              ent_next.flags      = '0;
              idx_next            = AW'(count);
              count_next          = count + COUNT_W'(1);
              state_next          = S_UP_RD;
            end
          end else if (!present[in_id]) begin
            status_r_next = ST_NOT_FOUND;
            state_next    = S_EMIT;
          end else begin
            state_next = S_LOOK;
          end
        end
      end

      S_LOOK: begin
        idx_next = sr_data;
        if (op == FUNC_CANCEL) begin
          present_next[IW'(id_r)] = 1'b0;
          count_next              = count - COUNT_W'(1);
          if (COUNT_W'(sr_data) < count - COUNT_W'(1)) begin
            hr_addr    = AW'(count - COUNT_W'(1));
            state_next = S_FETCH;
          end else begin
            state_next = S_EMIT;
          end
        end else begin
          hr_addr    = sr_data;
          state_next = S_FETCH;
        end
      end

      S_FETCH: begin
        hw_data = hr_data;
        case (op)
          FUNC_COMPLETE: begin
            if (hr_data.flags[FLAG_DONE_BIT]) begin
              status_r_next = ST_DONE;
            end else begin
              hw_en                        = 1'b1;
              hw_data.flags[FLAG_DONE_BIT] = 1'b1;
            end
            state_next = S_EMIT;
          end
          FUNC_PAUSE: begin
            if (hr_data.flags[FLAG_PAUSED_BIT]) begin
              status_r_next = ST_PAUSED;
            end else if (hr_data.flags[FLAG_DONE_BIT]) begin
              status_r_next = ST_DONE;
            end else begin
              hw_en                          = 1'b1;
              hw_data.flags[FLAG_PAUSED_BIT] = 1'b1;
            end
            state_next = S_EMIT;
          end
          FUNC_RESUME: begin
            if (!hr_data.flags[FLAG_PAUSED_BIT]) begin
              status_r_next = ST_NOT_PAUSED;
            end else if (hr_data.flags[FLAG_DONE_BIT]) begin
              status_r_next = ST_DONE;
            end else begin
              hw_en                          = 1'b1;
              hw_data.flags[FLAG_PAUSED_BIT] = 1'b0;
            end
            state_next = S_EMIT;
          end
          FUNC_RETIME: begin
            ent_next       = hr_data;
            ent_next.dur   = dur_r;
            ent_next.start = now_tick;
            state_next     = S_UP_RD;
          end
          FUNC_SETPRIO: begin
            ent_next      = hr_data;
            ent_next.prio = preq_r;
            state_next    = S_UP_RD;
          end
          default: begin
            ent_next   = hr_data;
            state_next = S_UP_RD;
          end
        endcase
      end

      S_UP_RD: begin
        if (idx == '0) begin
          state_next = S_DN_RDL;
        end else begin
          hr_addr    = parent;
          state_next = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        if (goes_before(ent, hr_data)) begin
          hw_en      = 1'b1;
          hw_data    = hr_data;
          sw_en      = 1'b1;
          sw_addr    = IW'(hr_data.task_id);
          idx_next   = parent;
          state_next = S_UP_RD;
        end else begin
          state_next = S_DN_RDL;
        end
      end

      S_DN_RDL: begin
        if (lchild >= {1'b0, count}) begin
          hw_en      = 1'b1;
          sw_en      = 1'b1;
          state_next = S_EMIT;
        end else begin
          hr_addr    = lchild[AW-1:0];
          state_next = S_DN_RDR;
        end
      end

      S_DN_RDR: begin
        cand_next = hr_data;
        r_ok_next = (rchild < {1'b0, count});
        hr_addr   = rchild[AW-1:0];
        state_next = S_DN_CMP;
      end

      S_DN_CMP: begin
        hw_en = 1'b1;
        if (take_r) begin
          hw_data    = hr_data;
          sw_en      = 1'b1;
          sw_addr    = IW'(hr_data.task_id);
          idx_next   = rchild[AW-1:0];
          state_next = S_DN_RDL;
        end else if (take_l) begin
          hw_data    = cand;
          sw_en      = 1'b1;
          sw_addr    = IW'(cand.task_id);
          idx_next   = lchild[AW-1:0];
          state_next = S_DN_RDL;
        end else begin
          sw_en      = 1'b1;
          state_next = S_EMIT;
        end
      end

      S_T_RD: begin
        hr_addr    = tidx[AW-1:0];
        state_next = S_T_MUL;
      end

      S_T_MUL: begin
        cand_next    = hr_data;
        elapsed_next = now_tick - hr_data.start;
        need_next    = TICK_W'(hr_data.dur) * TICK_W'(tpm);
        state_next   = S_T_CMP;
      end

      S_T_CMP: begin
        if (cand.flags == '0 && elapsed >= need) begin
          hw_en                        = 1'b1;
          hw_addr                      = tidx[AW-1:0];
          hw_data                      = cand;
          hw_data.flags[FLAG_DONE_BIT] = 1'b1;
          state_next                   = S_T_EMIT;
        end else begin
          tidx_next  = tidx_inc;
          state_next = (tidx_inc >= count) ? S_EMIT : S_T_RD;
        end
      end

      S_T_EMIT: begin
        if (out_free) begin
          out_valid_next           = 1'b1;
          out_data_next.status     = ST_OK;
          out_data_next.auto_done  = 1'b1;
          out_data_next.done_id    = cand.task_id;
          out_data_next.head_valid = head_valid;
          out_data_next.head_id    = head_out;
          out_data_next.task_count = count;
          out_data_next.last       = 1'b0;
          tidx_next                = tidx_inc;
          state_next               = (tidx_inc >= count) ? S_EMIT : S_T_RD;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_next           = 1'b1;
          out_data_next.status     = status_r;
          out_data_next.auto_done  = 1'b0;
          out_data_next.done_id    = '0;
          out_data_next.head_valid = head_valid;
          out_data_next.head_id    = head_out;
          out_data_next.task_count = count;
          out_data_next.last       = 1'b1;
          state_next               = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // root mirror for the head field
    if (hw_en && hw_addr == '0) begin
      head_next = hw_data.task_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      now_tick  <= '0;
      present   <= '0;
      tpm       <= TPM_RESET;
      defp      <= DEFP_RESET;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      now_tick  <= now_tick_next;
      present   <= present_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TPM:  tpm  <= cfg_data;
          CFG_DEFP: defp <= cfg_data[PRIO_W-1:0];
          default:  ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    head     <= head_next;
    op       <= op_next;
    id_r     <= id_r_next;
    dur_r    <= dur_r_next;
    preq_r   <= preq_r_next;
    status_r <= status_r_next;
    ent      <= ent_next;
    cand     <= cand_next;
    r_ok     <= r_ok_next;
    idx      <= idx_next;
    tidx     <= tidx_next;
    elapsed  <= elapsed_next;
    need     <= need_next;
    out_data <= out_data_next;
  end

  `ITT_ASSERT_NOW(a_count_cap, 1'b1, count <= COUNT_W'(CAPACITY), "task count above capacity")
  `ITT_ASSERT_NOW(a_write_held, hw_en, COUNT_W'(hw_addr) < count, "heap write beyond count")
  `ITT_ASSERT_NOW(a_idle_quiet, state == S_IDLE, !hw_en && !sw_en, "ram write while idle")
  `ITT_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")

endmodule

FILE: verif/indexed_priority_task_table_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed priority task table testbench
// Self-checking bench with a behavioral heap model. It runs directed and
// random operation mixes under several tick rates and default priorities,
// with bursty input, random output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module indexed_priority_task_table_unit_tb;
  import itt_pkg::*;

  localparam int CAP       = 32;
  localparam int IDS       = 128;
  localparam int DRAIN     = 200;
  localparam int MAX_CYC   = 1000000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  indexed_priority_task_table_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // task table model
  logic [ID_W-1:0]    m_heap[CAP];
  logic [5:0]         m_slot[IDS];
  bit                 m_present[IDS];
  logic [PRIO_W-1:0]  m_prio[IDS];
  logic [DUR_W-1:0]   m_dur[IDS];
  logic [TICK_W-1:0]  m_start[IDS];
  logic [FLAGS_W-1:0] m_flags[IDS];
  int unsigned        m_count;
  logic [TICK_W-1:0]  m_now;
  logic [DUR_W-1:0]   m_tpm;
  logic [PRIO_W-1:0]  m_defp;

  in_item_t    pending_ops[$];
  out_item_t   expected_results[$];
  int          errors = 0;
  int          accepted_ops = 0;
  int          checked_results = 0;
  int          auto_completions = 0;
  int          cycles = 0;

  function automatic bit sits_above(int a, int b);
    if (m_prio[a] != m_prio[b]) return m_prio[a] > m_prio[b];
    return m_dur[a] < m_dur[b];
  endfunction

  function automatic void swap_heap(int i, int j);
    logic [ID_W-1:0] t;
    t = m_heap[i];
    m_heap[i] = m_heap[j];
    m_heap[j] = t;
    m_slot[m_heap[i]] = 6'(i);
    m_slot[m_heap[j]] = 6'(j);
  endfunction

  function automatic void bubble_up(int i);
    while (i > 0 && sits_above(m_heap[i], m_heap[(i-1)/2])) begin
      swap_heap(i, (i-1)/2);
      i = (i-1)/2;
    end
  endfunction

  function automatic void bubble_down(int i);
    int best, l, r;
    forever begin
      best = i;
      l = 2*i + 1;
      r = 2*i + 2;
      if (l < m_count && sits_above(m_heap[l], m_heap[best])) best = l;
      if (r < m_count && sits_above(m_heap[r], m_heap[best])) best = r;
      if (best == i) return;
      swap_heap(i, best);
      i = best;
    end
  endfunction

  function automatic void push_result(logic [STATUS_W-1:0] st, logic ad,
                                      logic [ID_W-1:0] did, logic lst);
    out_item_t r;
    r.status     = st;
    r.auto_done  = ad;
    r.done_id    = did;
    r.head_valid = m_count > 0;
    r.head_id    = m_count > 0 ? m_heap[0] : '0;
    r.task_count = m_count[COUNT_W-1:0];
    r.last       = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void apply_op(in_item_t it);
    int id, pos, t;
    logic [STATUS_W-1:0] st;
    logic [TICK_W-1:0] elapsed;
    logic [TICK_W-1:0] need;
    id = it.task_id;
    st = ST_OK;
    if (it.func == FUNC_TICK) begin
      m_now = m_now + 1;
      for (int i = 0; i < m_count; i++) begin
        t = m_heap[i];
        if (m_flags[t] == 2'b00) begin
          elapsed = m_now - m_start[t];
          need = m_dur[t] * m_tpm;
          if (elapsed >= need) begin
            m_flags[t][FLAG_DONE_BIT] = 1'b1;
            push_result(ST_OK, 1'b1, ID_W'(t), 1'b0);
          end
        end
      end
      push_result(ST_OK, 1'b0, '0, 1'b1);
      return;
    end
    if (it.func == FUNC_ADD) begin
      if (m_count >= CAP) st = ST_FULL;
      else if (m_present[id]) st = ST_DUPLICATE;
      else begin
        m_present[id] = 1'b1;
        m_prio[id] = m_defp;
        m_dur[id] = it.duration;
        m_start[id] = m_now;
        m_flags[id] = 2'b00;
        m_heap[m_count] = ID_W'(id);
        m_slot[id] = 6'(m_count);
        m_count++;
        bubble_up(m_count - 1);
      end
    end else if (!m_present[id]) begin
      st = ST_NOT_FOUND;
    end else begin
      pos = m_slot[id];
      case (it.func)
        FUNC_COMPLETE: begin
          if (m_flags[id][FLAG_DONE_BIT]) st = ST_DONE;
          else m_flags[id][FLAG_DONE_BIT] = 1'b1;
        end
        FUNC_CANCEL: begin
          m_present[id] = 1'b0;
          m_count--;
          if (pos < m_count) begin
            m_heap[pos] = m_heap[m_count];
            m_slot[m_heap[pos]] = 6'(pos);
            bubble_up(pos);
            bubble_down(pos);
          end
        end
        FUNC_RETIME: begin
          m_dur[id] = it.duration;
          m_start[id] = m_now;
          bubble_up(pos);
          bubble_down(m_slot[id]);
        end
        FUNC_SETPRIO: begin
          m_prio[id] = it.priority_req;
          bubble_up(pos);
          bubble_down(m_slot[id]);
        end
        FUNC_PAUSE: begin
          if (m_flags[id][FLAG_PAUSED_BIT]) st = ST_PAUSED;
          else if (m_flags[id][FLAG_DONE_BIT]) st = ST_DONE;
          else m_flags[id][FLAG_PAUSED_BIT] = 1'b1;
        end
        default: begin
          if (!m_flags[id][FLAG_PAUSED_BIT]) st = ST_NOT_PAUSED;
          else if (m_flags[id][FLAG_DONE_BIT]) st = ST_DONE;
          else m_flags[id][FLAG_PAUSED_BIT] = 1'b0;
        end
      endcase
    end
    push_result(st, 1'b0, '0, 1'b1);
  endfunction

  // sender: bursts with gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_op(in_data);
        void'(pending_ops.pop_front());
        accepted_ops++;
      end
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_ops[0];
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long output hold-off while input keeps coming
  int hold_left = 0;
  bit hold_done = 0;
  logic hold_active = 1'b0;
  always @(posedge clk) begin
    if (!hold_done && accepted_ops >= 60) begin
      hold_done <= 1;
      hold_left <= 400;
      hold_active <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      hold_active <= hold_left > 1;
    end
  end

  // receiver stall pattern
  int stall_mode = 0;
  always @(posedge clk) begin
    if (cycles % 97 == 0) stall_mode <= $urandom_range(0, 2);
    if (hold_active) out_ready <= 1'b0;
    else if (stall_mode == 0) out_ready <= 1'b1;
    else if (stall_mode == 1) out_ready <= $urandom_range(0, 3) != 0;
    else out_ready <= $urandom_range(0, 3) == 0;
  end

  // result checker
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", out_data);
      end else begin
        e = expected_results.pop_front();
        checked_results++;
        if (e.auto_done) auto_completions++;
        if (out_data.status !== e.status || out_data.auto_done !== e.auto_done ||
            out_data.done_id !== e.done_id || out_data.head_valid !== e.head_valid ||
            out_data.head_id !== e.head_id || out_data.task_count !== e.task_count ||
            out_data.last !== e.last) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", e, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYC) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void queue_op(logic [FUNC_W-1:0] f, int id, int d, int p);
    in_item_t it;
    it.func = f;
    it.task_id = ID_W'(id);
    it.duration = DUR_W'(d);
    it.priority_req = PRIO_W'(p);
    pending_ops.push_back(it);
  endfunction

  function automatic void queue_random(int id_pool);
    int w, id, d;
    w = $urandom_range(0, 99);
    id = ($urandom_range(0, 9) == 0) ? $urandom_range(0, IDS-1)
                                      : $urandom_range(0, id_pool-1);
    d = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3);
    if (w < 25) queue_op(FUNC_TICK, id, d, $urandom_range(0, 255));
    else if (w < 55) queue_op(FUNC_ADD, id, d, $urandom_range(0, 255));
    else if (w < 63) queue_op(FUNC_CANCEL, id, d, $urandom_range(0, 255));
    else queue_op(FUNC_W'($urandom_range(2, 7)), id, d, $urandom_range(0, 255));
  endfunction

  task automatic wait_idle();
    while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    if (idx == CFG_TPM) m_tpm = DUR_W'(val);
    else m_defp = PRIO_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int tpm, int defp, int n, int pool);
    write_cfg(CFG_TPM, tpm);
    write_cfg(CFG_DEFP, defp);
    for (int i = 0; i < n; i++) queue_random(pool);
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < IDS; i++) m_present[i] = 1'b0;
    m_count = 0;
    m_now = '0;
    m_tpm = TPM_RESET;
    m_defp = DEFP_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes, every operation and every status but full
    queue_op(FUNC_TICK, 0, 0, 0);
    queue_op(FUNC_COMPLETE, 5, 0, 0);
    queue_op(FUNC_ADD, 0, 0, 0);
    queue_op(FUNC_ADD, 127, 65535, 255);
    queue_op(FUNC_ADD, 127, 1, 0);
    queue_op(FUNC_ADD, 42, 1, 0);
    queue_op(FUNC_TICK, 0, 0, 0);
    queue_op(FUNC_PAUSE, 42, 0, 0);
    queue_op(FUNC_PAUSE, 42, 0, 0);
    queue_op(FUNC_RESUME, 42, 0, 0);
    queue_op(FUNC_RESUME, 42, 0, 0);
    queue_op(FUNC_COMPLETE, 42, 0, 0);
    queue_op(FUNC_COMPLETE, 42, 0, 0);
    queue_op(FUNC_PAUSE, 0, 0, 0);
    queue_op(FUNC_RESUME, 127, 0, 0);
    queue_op(FUNC_SETPRIO, 127, 0, 255);
    queue_op(FUNC_SETPRIO, 42, 0, 0);
    queue_op(FUNC_RETIME, 127, 0, 0);
    queue_op(FUNC_RETIME, 9, 3, 0);
    queue_op(FUNC_TICK, 0, 0, 0);
    queue_op(FUNC_CANCEL, 0, 0, 0);
    queue_op(FUNC_CANCEL, 0, 0, 0);
    queue_op(FUNC_SETPRIO, 64, 0, 9);
    queue_op(FUNC_PAUSE, 100, 0, 0);
    queue_op(FUNC_RESUME, 1, 0, 0);
    wait_idle();

    random_phase(1, 0, 120, 48);
    random_phase(65535, 255, 80, 40);
    random_phase(3, 128, 100, 36);
    random_phase(2, 7, 90, 64);

    $display("ran %0d operations over 5 register settings, %0d results checked",
             accepted_ops, checked_results);
    $display("%0d time completions seen, %0d errors", auto_completions, errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
